/* hw/rtl/sem_pkg.sv */
`default_nettype none
package sem_pkg;

  localparam int MaxWidth = 1024;
  localparam int ColW = $clog2(MaxWidth + 1);
  localparam int AddrW = $clog2(MaxWidth);
  localparam int CntW = 11;
  localparam int EmitW = 21;
  localparam int PixW = 24;
  localparam int HeightLimit = 1024;
  localparam int ChMax = 255;
  localparam int SumW = 16;
  localparam int RootW = 9;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  localparam logic [2:0] REG_WIDTH = 3'd0;
  localparam logic [2:0] REG_HEIGHT = 3'd4;

  typedef struct packed {
    logic       op;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } in_req_t;

  typedef struct packed {
    logic [7:0] red_edge;
    logic [7:0] green_edge;
    logic [7:0] blue_edge;
    logic       frame_end;
  } out_req_t;

  // Border flags for one window position.
  typedef struct packed {
    logic [2:0] row_ok;
    logic [2:0] col_ok;
  } mask_t;

endpackage
`default_nettype wire

/* hw/rtl/sem_lane.sv */
`default_nettype none
// One color channel: Sobel gradients, squared sum, then a serial square root.
module sem_lane
  import sem_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       start,
  input  wire logic [7:0] win [9],
  input  wire mask_t      mask,
  output logic [7:0]      mag,
  output logic            done
);

  logic signed [11:0] gx, gy;
  logic signed [11:0] gx_r, gy_r;
  logic [SumW+6:0] sq_sum;
  logic [SumW+6:0] rem_r, rem_nxt;
  logic [SumW+6:0] root_r, root_nxt;
  logic [SumW+6:0] bit_r, bit_nxt;
  logic [SumW+6:0] sum_r;
  logic [2:0] stage_r;
  logic [3:0] step_r;
  logic [7:0] mag_r;
  logic done_r;
  logic [SumW+6:0] trial;
  logic [SumW+6:0] fin;

  always_comb begin
    logic signed [11:0] v [9];
    for (int i = 0; i < 9; i++) begin
      v[i] = (mask.col_ok[i/3] && mask.row_ok[i%3]) ? $signed({4'd0, win[i]}) : 12'sd0;
    end
    // v[col*3 + row]
    gx = (v[6] + (v[7] <<< 1) + v[8]) - (v[0] + (v[1] <<< 1) + v[2]);
    gy = (v[2] + (v[5] <<< 1) + v[8]) - (v[0] + (v[3] <<< 1) + v[6]);
  end

  assign sq_sum = 23'(gx_r * gx_r) + 23'(gy_r * gy_r);
  assign trial = root_r + bit_r;

  always_comb begin
    rem_nxt = rem_r;
    root_nxt = root_r >> 1;
    bit_nxt = bit_r >> 2;
    if (rem_r >= trial) begin
      rem_nxt = rem_r - trial;
      root_nxt = (root_r >> 1) + bit_r;
    end
  end

  assign fin = (sum_r - root_r * root_r > root_r) ? root_r + 23'd1 : root_r;

  always_ff @(posedge clk) begin
    done_r <= 1'b0;
    if (start) begin
      gx_r <= gx;
      gy_r <= gy;
      stage_r <= 3'd1;
    end else if (stage_r == 3'd1) begin
      sum_r <= sq_sum;
      rem_r <= sq_sum;
      root_r <= '0;
      bit_r <= 23'd1 << 22;
      step_r <= 4'd0;
      stage_r <= 3'd2;
    end else if (stage_r == 3'd2) begin
      rem_r <= rem_nxt;
      root_r <= root_nxt;
      bit_r <= bit_nxt;
      step_r <= step_r + 4'd1;
      if (step_r == 4'd11) stage_r <= 3'd3;
    end else if (stage_r == 3'd3) begin
      mag_r <= (fin > 23'(ChMax)) ? 8'(ChMax) : fin[7:0];
      done_r <= 1'b1;
      stage_r <= 3'd0;
    end else begin
      stage_r <= 3'd0;
    end
  end

  assign mag = mag_r;
  assign done = done_r;

endmodule
`default_nettype wire

/* hw/rtl/sobel_edge_magnitude_rgb.sv */
`default_nettype none
// Channel  Handshake          Payload
// in_      in_valid/in_stall  in_req_t
// out_     out_valid/out_stall out_req_t
// cfg_     APB write/read     frame_width, frame_height
// A pixel with a result passes through acceptance, line store read, window shift,
// gradient latch, squared sum, 12 square-root steps, rounding, result load and
// the output handshake. A pixel without a result ends after the window shift.
// A drain or a pixel after a complete frame may advance two positions.
// Reset is synchronous; line stores are not cleared.
// Input stalls while a request is in work, a result waits or a configuration write is under way.
module sobel_edge_magnitude_rgb
  import sem_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire in_req_t     in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output out_req_t         out_data,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  typedef enum logic [2:0] {S_IDLE, S_READ, S_ADV, S_RUN, S_OUT} state_t;

  logic [PixW-1:0] store_a [MaxWidth];
  logic [PixW-1:0] store_b [MaxWidth];
  logic [PixW-1:0] old_a_r, old_b_r;
  logic [PixW-1:0] win_r [9];
  logic [PixW-1:0] pix_r;
  logic real_r, second_r;
  logic go_r;
  state_t state_r;
  logic [CntW-1:0] fw_r, fh_r, col_r, row_r;
  logic [EmitW-1:0] emit_r;
  logic [CntW-1:0] w, h;
  logic [AddrW-1:0] idx;
  mask_t mask_r;
  logic fe_r;
  logic [7:0] win_ch [3][9];
  logic [7:0] mag [3];
  logic [2:0] done;
  logic cfg_wr;
  out_req_t out_r;

  assign w = (fw_r == '0) ? CntW'(1) : (fw_r > CntW'(MaxWidth)) ? CntW'(MaxWidth) : fw_r;
  assign h = (fh_r == '0) ? CntW'(1) : (fh_r > CntW'(HeightLimit)) ? CntW'(HeightLimit) : fh_r;
  assign idx = (col_r < CntW'(MaxWidth)) ? col_r[AddrW-1:0] : '0;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == REG_HEIGHT) ? 32'(fh_r) : (cfg_paddr == REG_WIDTH) ? 32'(fw_r) : '0;
  assign in_stall = (state_r != S_IDLE) || cfg_wr;
  assign out_valid = (state_r == S_OUT);
  assign out_data = out_r;

  always_ff @(posedge clk) begin
    if (state_r == S_READ) begin
      old_a_r <= store_a[idx];
      old_b_r <= store_b[idx];
    end
    if (state_r == S_ADV && real_r) begin
      store_a[idx] <= old_b_r;
      store_b[idx] <= pix_r;
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_lane
    for (genvar k = 0; k < 9; k++) begin : g_w
      assign win_ch[c][k] = win_r[k][23-8*c -: 8];
    end
    sem_lane u_lane (
      .clk  (clk),
      .start(go_r),
      .win  (win_ch[c]),
      .mask (mask_r),
      .mag  (mag[c]),
      .done (done[c])
    );
  end

  always_ff @(posedge clk) begin
    logic [CntW:0] r, c;
    logic prod_hit;
    r = '0;
    c = '0;
    prod_hit = 1'b0;
    if (!rst_n) begin
      state_r <= S_IDLE;
      go_r <= 1'b0;
      fw_r <= 11'd640;
      fh_r <= 11'd480;
      col_r <= '0;
      row_r <= '0;
      emit_r <= '0;
      for (int i = 0; i < 9; i++) win_r[i] <= '0;
    end else if (cfg_wr) begin
      if (cfg_paddr == REG_WIDTH) fw_r <= cfg_pwdata[CntW-1:0];
      if (cfg_paddr == REG_HEIGHT) fh_r <= cfg_pwdata[CntW-1:0];
      col_r <= '0;
      row_r <= '0;
      emit_r <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            if (row_r < h) begin
              if (in_data.op == OP_PIXEL) begin
                real_r <= 1'b1;
                second_r <= 1'b0;
                pix_r <= {in_data.red_in, in_data.green_in, in_data.blue_in};
                state_r <= S_READ;
              end
            end else begin
              real_r <= 1'b0;
              second_r <= 1'b1;
              pix_r <= '0;
              state_r <= S_READ;
            end
          end
        end
        S_READ: state_r <= S_ADV;
        S_ADV: begin
          for (int i = 0; i < 6; i++) win_r[i] <= win_r[i+3];
          win_r[6] <= old_a_r;
          win_r[7] <= old_b_r;
          win_r[8] <= pix_r;
          if (col_r + 11'd1 >= w) begin
            col_r <= '0;
            row_r <= row_r + 11'd1;
          end else begin
            col_r <= col_r + 11'd1;
          end
          if (row_r >= 2 || (row_r == 1 && col_r >= 1)) begin
            if (col_r == 0) begin
              r = 12'(row_r) - 12'd2;
              c = 12'(w) - 12'd1;
            end else begin
              r = 12'(row_r) - 12'd1;
              c = 12'(col_r) - 12'd1;
            end
            mask_r.row_ok <= {$signed(r) <= $signed(12'(h) - 12'sd2), 1'b1, $signed(r) >= 12'sd1};
            mask_r.col_ok <= {$signed(c) <= $signed(12'(w) - 12'sd2), 1'b1, $signed(c) >= 12'sd1};
            prod_hit = 32'(emit_r) + 32'd1 >= 32'(w) * 32'(h);
            fe_r <= prod_hit;
            if (prod_hit) begin
              emit_r <= '0;
              col_r <= '0;
              row_r <= '0;
            end else begin
              emit_r <= emit_r + 21'd1;
            end
            go_r <= 1'b1;
            state_r <= S_RUN;
          end else if (second_r) begin
            second_r <= 1'b0;
            state_r <= S_READ;
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_RUN: begin
          go_r <= 1'b0;
          if (&done) begin
            out_r <= '{red_edge: mag[0], green_edge: mag[1], blue_edge: mag[2],
                       frame_end: fe_r};
            state_r <= S_OUT;
          end
        end
        S_OUT: if (!out_stall) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/sem_checker.sv */
`default_nettype none
module sem_checker
  import sem_pkg::*;
(
  input wire logic     clk,
  input wire logic     rst_n,
  input wire logic     in_valid,
  input wire logic     in_stall,
  input wire logic     out_valid,
  input wire logic     out_stall,
  input wire out_req_t out_data
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data)) else $error("result dropped");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("input taken while result waits");
  a_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> !out_valid) else $error("result raised right after a request");

endmodule

bind sobel_edge_magnitude_rgb sem_checker u_sem_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);
`default_nettype wire

/* sim/sobel_edge_magnitude_rgb_tb.sv */
`timescale 1ns / 1ps
module sobel_edge_magnitude_rgb_tb
  import sem_pkg::*;
;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_req_t     in_data;
  logic        out_valid;
  logic        out_stall;
  out_req_t    out_data;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  sobel_edge_magnitude_rgb uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  in_req_t  pixel_q[$];
  out_req_t edge_q[$];
  int       error_count;
  int       sender_idle_pct;
  int       stall_pct;
  int       item_total;

  // Shadow of the filter state.
  logic [10:0] width_reg, height_reg;
  logic [23:0] line_a[MaxWidth];
  logic [23:0] line_b[MaxWidth];
  logic [23:0] win[3][3];
  int          col_pos, row_pos, emit_pos;
  bit          saw_frame_end;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int eff_w();
    if (width_reg < 1) return 1;
    if (width_reg > MaxWidth) return MaxWidth;
    return width_reg;
  endfunction

  function automatic int eff_h();
    if (height_reg < 1) return 1;
    if (height_reg > HeightLimit) return HeightLimit;
    return height_reg;
  endfunction

  function automatic logic [7:0] grad_mag(int gx, int gy);
    int s;
    int r;
    s = gx * gx + gy * gy;
    r = 0;
    while ((r + 1) * (r + 1) <= s) r++;
    if (s - r * r > r) r++;
    return (r > ChMax) ? 8'd255 : r[7:0];
  endfunction

  function automatic bit advance_pos(logic [23:0] pix, bit real_pix);
    int w, h, c_in, r_in, idx, r, c, gx, gy, v;
    logic [23:0] old_a, old_b;
    bit row_ok[3], col_ok[3];
    out_req_t res;
    w = eff_w();
    h = eff_h();
    c_in = col_pos;
    r_in = row_pos;
    idx = (c_in < MaxWidth) ? c_in : 0;
    old_a = line_a[idx];
    old_b = line_b[idx];
    if (real_pix) begin
      line_a[idx] = old_b;
      line_b[idx] = pix;
    end
    win[0] = win[1];
    win[1] = win[2];
    win[2][0] = old_a;
    win[2][1] = old_b;
    win[2][2] = pix;
    if (c_in + 1 >= w) begin
      col_pos = 0;
      row_pos = r_in + 1;
    end else begin
      col_pos = c_in + 1;
    end
    if (!(r_in >= 2 || (r_in == 1 && c_in >= 1))) return 0;
    if (c_in == 0) begin
      r = r_in - 2;
      c = w - 1;
    end else begin
      r = r_in - 1;
      c = c_in - 1;
    end
    row_ok = '{r >= 1, 1'b1, r <= h - 2};
    col_ok = '{c >= 1, 1'b1, c <= w - 2};
    for (int ch = 0; ch < 3; ch++) begin
      gx = 0;
      gy = 0;
      for (int dy = 0; dy < 3; dy++) begin
        for (int dx = 0; dx < 3; dx++) begin
          if (row_ok[dy] && col_ok[dx]) begin
            v = (win[dx][dy] >> (16 - 8 * ch)) & 8'hFF;
            gx += v * ((dx - 1) * ((dy == 1) ? 2 : 1));
            gy += v * ((dy - 1) * ((dx == 1) ? 2 : 1));
          end
        end
      end
      case (ch)
        0: res.red_edge = grad_mag(gx, gy);
        1: res.green_edge = grad_mag(gx, gy);
        default: res.blue_edge = grad_mag(gx, gy);
      endcase
    end
    if (emit_pos + 1 >= w * h) begin
      res.frame_end = 1'b1;
      saw_frame_end = 1'b1;
      col_pos = 0;
      row_pos = 0;
      emit_pos = 0;
    end else begin
      res.frame_end = 1'b0;
      emit_pos++;
    end
    edge_q.push_back(res);
    return 1;
  endfunction

  function automatic void add_request(logic op, logic [23:0] pix);
    in_req_t rq;
    rq.op = op;
    {rq.red_in, rq.green_in, rq.blue_in} = pix;
    pixel_q.push_back(rq);
    item_total++;
    if (row_pos < eff_h()) begin
      if (op == OP_PIXEL) void'(advance_pos(pix, 1'b1));
    end else if (!advance_pos(24'd0, 1'b0)) begin
      void'(advance_pos(24'd0, 1'b0));
    end
  endfunction

  function automatic logic [23:0] make_pixel(int mode, int i);
    case (mode)
      0: return 24'h000000;
      1: return 24'hFFFFFF;
      2: return ((i % 2) != 0) ? 24'hFFFFFF : 24'h000000;
      default: return {8'($urandom_range(255)), 8'($urandom_range(255)),
                       8'($urandom_range(255))};
    endcase
  endfunction

  // One frame of pixels with some drain noise. A partial frame is cut short and ends there; a full
  // one is followed by drain ticks (now and then a pixel) until the last result has been queued.
  function automatic void add_frame(int mode, bit partial);
    int n;
    n = eff_w() * eff_h();
    if (partial) n = $urandom_range(n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(15) == 0) add_request(OP_DRAIN, make_pixel(3, i));
      add_request(OP_PIXEL, make_pixel(mode, i));
    end
    if (partial) return;
    saw_frame_end = 1'b0;
    while (!saw_frame_end) begin
      if ($urandom_range(7) == 0) add_request(OP_PIXEL, make_pixel(3, 0));
      else add_request(OP_DRAIN, make_pixel(3, 0));
    end
  endfunction

  task automatic wait_idle();
    do @(posedge clk);
    while (pixel_q.size() != 0 || in_valid || edge_q.size() != 0);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] addr, logic [31:0] value);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk);
    while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    if (addr == REG_WIDTH) width_reg = value[10:0];
    else height_reg = value[10:0];
    col_pos = 0;
    row_pos = 0;
    emit_pos = 0;
  endtask

  task automatic run_phase(int w, int h, int frames, int mode, bit partial, int idle_mode);
    wait_idle();
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    case (idle_mode % 4)
      0: begin sender_idle_pct = 0; stall_pct = 0; end
      1: begin sender_idle_pct = 63; stall_pct = 0; end
      2: begin sender_idle_pct = 0; stall_pct = 63; end
      default: begin sender_idle_pct = 11; stall_pct = 11; end
    endcase
    for (int f = 0; f < frames; f++) add_frame(mode, 1'b0);
    if (partial) add_frame(3, 1'b1);
  endtask

  task automatic report_mismatch(string what, out_req_t got, out_req_t want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    error_count++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (pixel_q.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        in_data <= pixel_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    out_req_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (edge_q.size() == 0) begin
        report_mismatch("unexpected request", out_data, '0);
      end else begin
        want = edge_q.pop_front();
        if (out_data.red_edge !== want.red_edge) report_mismatch("red", out_data, want);
        if (out_data.green_edge !== want.green_edge) report_mismatch("green", out_data, want);
        if (out_data.blue_edge !== want.blue_edge) report_mismatch("blue", out_data, want);
        if (out_data.frame_end !== want.frame_end) report_mismatch("frame_end", out_data, want);
      end
    end
  end

  initial begin
    #(12 * 4000000);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    error_count = 0;
    item_total = 0;
    sender_idle_pct = 0;
    stall_pct = 0;
    width_reg = 11'd640;
    height_reg = 11'd480;
    col_pos = 0;
    row_pos = 0;
    emit_pos = 0;
    foreach (line_a[i]) begin
      line_a[i] = '0;
      line_b[i] = '0;
    end
    foreach (win[i, j]) win[i][j] = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    run_phase(3, 3, 1, 0, 1'b0, 0);
    run_phase(3, 3, 1, 1, 1'b0, 1);
    run_phase(4, 3, 1, 2, 1'b0, 2);
    run_phase(1, 1, 2, 3, 1'b0, 3);
    run_phase(0, 0, 1, 1, 1'b0, 0);
    run_phase(5, 1, 1, 3, 1'b0, 1);
    run_phase(1, 4, 1, 3, 1'b1, 2);
    run_phase(1, 2047, 1, 3, 1'b0, 3);
    for (int p = 0; item_total < 1400; p++) begin
      run_phase($urandom_range(1, 12), $urandom_range(1, 8), $urandom_range(1, 3), 3,
                ($urandom_range(5) == 0), p);
    end
    wait_idle();
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
